### rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
package sem_pkg;

	localparam int SEM_MAX_WIDTH  = 1024;
	localparam int SEM_MAX_HEIGHT = 1024;

	localparam int SEM_PIX_W        = 8;
	localparam int SEM_CFG_DATA_W   = 11;
	localparam int SEM_CFG_INDEX_W  = 2;
	localparam int SEM_RESET_WIDTH  = 640;
	localparam int SEM_RESET_HEIGHT = 480;
	localparam int SEM_MIN_DIM      = 3;

	localparam logic [SEM_PIX_W-1:0] SEM_PIX_MAX = 8'd255;

	// Configuration register indexes.
	localparam logic [SEM_CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [SEM_CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef logic [SEM_PIX_W-1:0] pixel_t;

	// Three horizontally adjacent pixels: [0] is the left one, [2] the right one.
	typedef logic [2:0][SEM_PIX_W-1:0] row_t;

	typedef struct packed {
		row_t top;
		row_t mid;
		row_t bot;
	} window_t;

endpackage

### rtl/sem_line_store.sv
// Pixel history memory that delivers the 3x3 window for the newest pixel.
module sem_line_store #(
	parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH,
	parameter int DIM_W     = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sem_pkg::pixel_t      pixel,
	input  logic [DIM_W-1:0]     width,
	output sem_pkg::window_t     window_s1
);
	import sem_pkg::*;

	localparam int AW    = $clog2(2 * MAX_WIDTH + 1);
	localparam int DEPTH = 1 << AW;

	// Each word holds a pixel and the two pixels before it, so one read yields a row.
	row_t mem [DEPTH];

	logic [AW-1:0] wr_ptr_q;
	pixel_t        hist1_q;
	pixel_t        hist2_q;
	row_t          word;
	logic [AW-1:0] addr_mid;
	logic [AW-1:0] addr_top;

	assign word     = {pixel, hist1_q, hist2_q};
	assign addr_mid = wr_ptr_q - AW'(width);
	assign addr_top = wr_ptr_q - AW'({width, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			hist1_q  <= '0;
			hist2_q  <= '0;
		end else if (load) begin
			wr_ptr_q <= wr_ptr_q + AW'(1);
			hist1_q  <= pixel;
			hist2_q  <= hist1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mem[wr_ptr_q]    <= word;
			window_s1.mid    <= mem[addr_mid];
			window_s1.top    <= mem[addr_top];
			window_s1.bot    <= word;
		end
	end

endmodule

### rtl/sobel_edge_magnitude_unit.sv
// Top level of the Sobel edge magnitude unit: position tracking, window math, output stage.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_stall, pixel, frame_start       | in, stall out
//  result  | out_valid, out_stall, edge_value,            | out, stall in
//          | center_index, last_of_frame                  |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data    | in, ready out
//
// One pixel is taken per cycle unless stalled; results pass window_s1, then edge_q.
// The rate is set by the history memory, which takes one write and two row reads per cycle.
// Reset clears position, pipeline valids and the history pointer, and loads 640 x 480.
// The input stalls only while a result waits in the window stage and the output is stalled.
// Configuration writes are taken in any cycle and act on the next pixel.
module sobel_edge_magnitude_unit #(
	parameter int MAX_WIDTH  = sem_pkg::SEM_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::SEM_MAX_HEIGHT,
	parameter int POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  sem_pkg::pixel_t                     pixel,
	input  logic                                frame_start,
	output logic                                out_valid,
	input  logic                                out_stall,
	output sem_pkg::pixel_t                     edge_value,
	output logic [POS_W-1:0]                    center_index,
	output logic                                last_of_frame,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sem_pkg::SEM_CFG_INDEX_W-1:0] cfg_index,
	input  logic [sem_pkg::SEM_CFG_DATA_W-1:0]  cfg_data
);
	import sem_pkg::*;

	localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W    = $clog2(MAX_DIM + 1);
	localparam int CW       = (DIM_W > SEM_CFG_DATA_W) ? DIM_W : SEM_CFG_DATA_W;
	localparam int RST_W    = (SEM_RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : SEM_RESET_WIDTH;
	localparam int RST_H    = (SEM_RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : SEM_RESET_HEIGHT;
	localparam int RST_LAST = RST_W * RST_H - 1;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CW-1:0] v,
			input logic [CW-1:0] hi);
		logic [CW-1:0] r;
		if (v < CW'(SEM_MIN_DIM))
			r = CW'(SEM_MIN_DIM);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return DIM_W'(r);
	endfunction

	function automatic logic [POS_W-1:0] last_pos(input logic [DIM_W-1:0] a,
			input logic [DIM_W-1:0] b);
		logic [2*DIM_W-1:0] p;
		p = (2*DIM_W)'(a) * (2*DIM_W)'(b);
		return POS_W'(p - (2*DIM_W)'(1));
	endfunction

	function automatic logic signed [11:0] ext(input pixel_t x);
		return $signed({4'b0000, x});
	endfunction

	function automatic pixel_t sobel_mag(input window_t win);
		logic signed [11:0] gx;
		logic signed [11:0] gy;
		logic [10:0]        ax;
		logic [10:0]        ay;
		logic [8:0]         cx;
		logic [8:0]         cy;
		logic [9:0]         s;
		gx = ext(win.top[0]) - ext(win.top[2])
			+ ((ext(win.mid[0]) - ext(win.mid[2])) <<< 1)
			+ ext(win.bot[0]) - ext(win.bot[2]);
		gy = ext(win.top[0]) - ext(win.bot[0])
			+ ((ext(win.top[1]) - ext(win.bot[1])) <<< 1)
			+ ext(win.top[2]) - ext(win.bot[2]);
		ax = gx[11] ? 11'(-gx) : 11'(gx);
		ay = gy[11] ? 11'(-gy) : 11'(gy);
		cx = (ax > 11'(SEM_PIX_MAX)) ? 9'(SEM_PIX_MAX) : 9'(ax);
		cy = (ay > 11'(SEM_PIX_MAX)) ? 9'(SEM_PIX_MAX) : 9'(ay);
		s  = 10'(cx) + 10'(cy);
		return (s > 10'(SEM_PIX_MAX)) ? SEM_PIX_MAX : s[7:0];
	endfunction

	// Configuration, kept already clamped, with the last raster index of the frame.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [POS_W-1:0] last_pos_q;
	logic [DIM_W-1:0] new_w;
	logic [DIM_W-1:0] new_h;

	assign cfg_ready = 1'b1;
	assign new_w     = clamp_dim(CW'(cfg_data), CW'(MAX_WIDTH));
	assign new_h     = clamp_dim(CW'(cfg_data), CW'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_W'(RST_W);
			height_q   <= DIM_W'(RST_H);
			last_pos_q <= POS_W'(RST_LAST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q    <= new_w;
					last_pos_q <= last_pos(new_w, height_q);
				end
				REG_IMAGE_HEIGHT: begin
					height_q   <= new_h;
					last_pos_q <= last_pos(width_q, new_h);
				end
				default: ;
			endcase
		end
	end

	// Position of the incoming pixel and whether it completes a window.
	logic             accept;
	logic             out_ready;
	logic             valid_s1;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_in;
	logic [POS_W-1:0] first_pos;
	logic             produce;

	assign out_ready = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !out_ready;
	assign accept    = in_valid && !in_stall;

	assign pos_in    = frame_start ? '0 : pos_q;
	assign first_pos = POS_W'({width_q, 1'b0}) + POS_W'(2);
	assign produce   = (pos_in >= first_pos) && (pos_in <= last_pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			// A position past the frame end also wraps, which covers a mid-frame resize.
			pos_q <= (pos_in >= last_pos_q) ? '0 : pos_in + POS_W'(1);
		end
	end

	window_t          window_s1;
	logic [POS_W-1:0] center_s1;
	logic             last_s1;

	sem_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.DIM_W     (DIM_W)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.pixel     (pixel),
		.width     (width_q),
		.window_s1 (window_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= produce;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			center_s1 <= pos_in - POS_W'(width_q) - POS_W'(1);
			last_s1   <= (pos_in == last_pos_q);
		end
	end

	// Result register.
	logic             out_valid_q;
	pixel_t           edge_q;
	logic [POS_W-1:0] center_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && out_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_ready) begin
			edge_q   <= sobel_mag(window_s1);
			center_q <= center_s1;
			last_q   <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign edge_value    = edge_q;
	assign center_index  = center_q;
	assign last_of_frame = last_q;

endmodule

### rtl/sem_checker.sv
// Port-level checks for the Sobel edge magnitude unit, bound to the top level.
module sem_checker #(
	parameter int POS_W = 20
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input sem_pkg::pixel_t        edge_value,
	input logic [POS_W-1:0]       center_index,
	input logic                   last_of_frame
);
	import sem_pkg::*;

	// The input side is held back only by a result stalled at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output can move");

	// A new result traces back to an input transfer through the window stage.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching input transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(edge_value)
			&& $stable(center_index) && $stable(last_of_frame)))
		else $error("stalled result changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result withdrawn without a transfer");

endmodule

bind sobel_edge_magnitude_unit sem_checker #(
	.POS_W (POS_W)
) u_sem_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.edge_value    (edge_value),
	.center_index  (center_index),
	.last_of_frame (last_of_frame)
);

### tb/sv/testbench.sv
// Self-checking testbench for the Sobel edge magnitude unit, with its own prediction.
module testbench;
	import sem_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int POS_W          = $clog2(SEM_MAX_WIDTH * SEM_MAX_HEIGHT);
	localparam int LINE_DEPTH     = 2 * SEM_MAX_WIDTH + 3;
	localparam int RANDOM_ITEMS   = 1350;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 300;
	localparam int DRAIN_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TIMEOUT_CYCLES = 2000000;

	// Indexes that decode to no register; writes to them must be ignored.
	localparam logic [SEM_CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [SEM_CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		pixel_t px;
		logic   fs;
	} pixel_item_t;

	typedef struct {
		pixel_t           magnitude;
		logic [POS_W-1:0] center;
		logic             last;
	} edge_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	pixel_t                     pixel = '0;
	logic                       frame_start = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	pixel_t                     edge_value;
	logic [POS_W-1:0]           center_index;
	logic                       last_of_frame;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [SEM_CFG_INDEX_W-1:0] cfg_index = '0;
	logic [SEM_CFG_DATA_W-1:0]  cfg_data = '0;

	pixel_item_t  pending_pixels[$];
	edge_result_t expected_edges[$];

	// Predicted block state and configuration.
	pixel_t                    line_hist[LINE_DEPTH] = '{default: '0};
	int                        line_head = 0;
	int                        next_pos = 0;
	logic [SEM_CFG_DATA_W-1:0] width_reg = SEM_CFG_DATA_W'(SEM_RESET_WIDTH);
	logic [SEM_CFG_DATA_W-1:0] height_reg = SEM_CFG_DATA_W'(SEM_RESET_HEIGHT);

	int   fail_count = 0;
	int   pixels_sent = 0;
	int   results_checked = 0;
	int   frame_ends = 0;
	int   widest = 0;
	int   tallest = 0;
	logic hold_off = 1'b0;

	int   tx_gap = 0;
	int   tx_ticks = 0;
	logic tx_quiet = 1'b0;
	int   rx_stall_left = 0;
	int   rx_ticks = 0;
	logic rx_quiet = 1'b0;

	sobel_edge_magnitude_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.edge_value   (edge_value),
		.center_index (center_index),
		.last_of_frame(last_of_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int clamp_dim(input logic [SEM_CFG_DATA_W-1:0] v, input int hi);
		if (v < SEM_MIN_DIM) return SEM_MIN_DIM;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int sat_abs(input int v);
		if (v < 0) v = -v;
		return (v > SEM_PIX_MAX) ? SEM_PIX_MAX : v;
	endfunction

	function automatic pixel_t line_tap(input int back);
		return line_hist[(line_head - back + LINE_DEPTH) % LINE_DEPTH];
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pixel_t rand_pixel();
		case ($urandom_range(0, 3))
			0, 1: return pixel_t'($urandom_range(0, 255));
			2: return $urandom_range(0, 1) ? SEM_PIX_MAX : pixel_t'(0);
			default: return pixel_t'($urandom_range(100, 140));
		endcase
	endfunction

	// Advances the predicted delay line and position by one pixel and records the
	// result that the pixel completes, if any.
	task automatic predict_edge(input pixel_t px, input logic fs);
		int w, h, total, pos, gx, gy, mag;
		int tl, tc, tr, ml, mr, bl, bc, br;
		edge_result_t r;
		w = clamp_dim(width_reg, SEM_MAX_WIDTH);
		h = clamp_dim(height_reg, SEM_MAX_HEIGHT);
		total = w * h;
		pos = fs ? 0 : next_pos;
		line_head = (line_head + 1) % LINE_DEPTH;
		line_hist[line_head] = px;
		if (pos >= 2 * w + 2 && pos <= total - 1) begin
			tl = line_tap(2 * w + 2);
			tc = line_tap(2 * w + 1);
			tr = line_tap(2 * w);
			ml = line_tap(w + 2);
			mr = line_tap(w);
			bl = line_tap(2);
			bc = line_tap(1);
			br = line_tap(0);
			gx = (tl - tr) + 2 * (ml - mr) + (bl - br);
			gy = (tl - bl) + 2 * (tc - bc) + (tr - br);
			mag = sat_abs(gx) + sat_abs(gy);
			if (mag > SEM_PIX_MAX) mag = SEM_PIX_MAX;
			r.magnitude = pixel_t'(mag);
			r.center = POS_W'(pos - w - 1);
			r.last = (pos == total - 1);
			expected_edges.push_back(r);
			if (w > widest) widest = w;
			if (h > tallest) tallest = h;
		end
		// A position past the end of the frame also wraps; this follows a mid-frame resize.
		next_pos = (pos >= total - 1) ? 0 : pos + 1;
		pixels_sent++;
	endtask

	task automatic queue_pixel(input pixel_t px, input logic fs);
		pending_pixels.push_back('{px: px, fs: fs});
	endtask

	task automatic write_reg(input logic [SEM_CFG_INDEX_W-1:0] idx,
			input logic [SEM_CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) width_reg = val;
		else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
	endtask

	// Waits until every queued pixel is taken and every predicted result has come out,
	// then lets the pipeline settle so that a pixel without a result is done too.
	// Checks are made at the falling edge, when the driver's updates have settled.
	task automatic drain();
		int waited;
		do @(negedge clk); while (pending_pixels.size() != 0 || in_valid);
		waited = 0;
		while (expected_edges.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_edges.size() != 0) begin
			$error("%0d expected results never arrived", expected_edges.size());
			fail_count++;
			expected_edges.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin : pixel_driver
		pixel_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (tx_gap > 0 || pending_pixels.size() == 0) begin
				in_valid <= 1'b0;
				if (tx_gap > 0) tx_gap--;
			end else begin
				item = pending_pixels.pop_front();
				pixel <= item.px;
				frame_start <= item.fs;
				in_valid <= 1'b1;
				tx_gap = tx_quiet ? 0 : pick_gap();
			end
		end
		tx_ticks++;
		if (tx_ticks % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) predict_edge(pixel, frame_start);
	end

	always @(posedge clk) begin : stall_driver
		if (hold_off) begin
			out_stall <= 1'b1;
		end else if (rx_stall_left > 0) begin
			out_stall <= 1'b1;
			rx_stall_left--;
		end else begin
			rx_stall_left = rx_quiet ? 0 : pick_gap();
			out_stall <= (rx_stall_left > 0);
			if (rx_stall_left > 0) rx_stall_left--;
		end
		rx_ticks++;
		if (rx_ticks % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin : edge_monitor
		edge_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_edges.size() == 0) begin
				$error("result with no expectation: edge_value %0d, center_index %0d",
					edge_value, center_index);
				fail_count++;
			end else begin
				want = expected_edges.pop_front();
				if (edge_value !== want.magnitude) begin
					$error("edge_value: expected %0d, actual %0d", want.magnitude, edge_value);
					fail_count++;
				end
				if (center_index !== want.center) begin
					$error("center_index: expected %0d, actual %0d", want.center, center_index);
					fail_count++;
				end
				if (last_of_frame !== want.last) begin
					$error("last_of_frame: expected %0d, actual %0d", want.last, last_of_frame);
					fail_count++;
				end
				if (want.last) frame_ends++;
			end
			results_checked++;
		end
	end

	// Long output hold while the sender keeps offering pixels, so the block backs up.
	initial begin
		wait (pixels_sent >= HOLD_AFTER);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		pixel_t left_bright[9];
		int phase_no, random_sent, n, total, i;
		logic [SEM_CFG_DATA_W-1:0] w_code, h_code;
		logic start_fs, fs, noisy;

		left_bright = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0};
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Smallest frame: a bright left column saturates the horizontal gradient.
		write_reg(REG_IMAGE_WIDTH, SEM_CFG_DATA_W'(SEM_MIN_DIM));
		write_reg(REG_IMAGE_HEIGHT, SEM_CFG_DATA_W'(SEM_MIN_DIM));
		for (i = 0; i < 9; i++) queue_pixel(left_bright[i], i == 0);
		drain();

		// A 4x4 frame left unfinished, then a shrink to 3x3 puts the position past the end.
		write_reg(REG_IMAGE_WIDTH, 11'd4);
		write_reg(REG_IMAGE_HEIGHT, 11'd4);
		for (i = 0; i < 11; i++) queue_pixel((i % 2) ? SEM_PIX_MAX : pixel_t'(0), i == 0);
		drain();
		write_reg(REG_IMAGE_WIDTH, SEM_CFG_DATA_W'(SEM_MIN_DIM));
		write_reg(REG_IMAGE_HEIGHT, SEM_CFG_DATA_W'(SEM_MIN_DIM));
		for (i = 0; i < 3; i++) queue_pixel(rand_pixel(), 1'b0);
		drain();

		phase_no = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS || phase_no < 9) begin
			phase_no++;
			noisy = 1'b0;
			start_fs = 1'b1;
			if (phase_no == 3) begin
				w_code = 11'd160;
				h_code = SEM_CFG_DATA_W'(SEM_MIN_DIM);
				n = 360;
			end else if (phase_no == 6) begin
				w_code = SEM_CFG_DATA_W'(SEM_MIN_DIM);
				h_code = 11'd2047;
				n = 60;
			end else if (phase_no == 9) begin
				w_code = 11'd2047;
				h_code = SEM_CFG_DATA_W'(SEM_MIN_DIM);
				n = 40;
			end else begin
				w_code = ($urandom_range(0, 99) < 8) ? SEM_CFG_DATA_W'($urandom_range(0, 2))
					: SEM_CFG_DATA_W'($urandom_range(3, 9));
				h_code = ($urandom_range(0, 99) < 8) ? SEM_CFG_DATA_W'($urandom_range(0, 2))
					: SEM_CFG_DATA_W'($urandom_range(3, 6));
				total = clamp_dim(w_code, SEM_MAX_WIDTH) * clamp_dim(h_code, SEM_MAX_HEIGHT);
				n = total * $urandom_range(1, 3);
				if ($urandom_range(0, 3) == 0) n += $urandom_range(1, total - 1);
				start_fs = ($urandom_range(0, 3) != 0);
				noisy = 1'b1;
			end
			random_sent += n;
			total = clamp_dim(w_code, SEM_MAX_WIDTH) * clamp_dim(h_code, SEM_MAX_HEIGHT);
			write_reg(REG_IMAGE_WIDTH, w_code);
			write_reg(REG_IMAGE_HEIGHT, h_code);
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					SEM_CFG_DATA_W'($urandom));
			for (i = 0; i < n; i++) begin
				if (i == 0) fs = start_fs;
				else if (!noisy) fs = 1'b0;
				else if (i % total == 0) fs = ($urandom_range(0, 1) == 0);
				else fs = ($urandom_range(0, 24) == 0);
				queue_pixel(rand_pixel(), fs);
			end
			drain();
		end

		$display("testbench: %0d pixels sent, %0d results checked, %0d frame ends seen",
			pixels_sent, results_checked, frame_ends);
		$display("testbench: frames up to %0d wide and %0d tall, with gaps, stalls and a long hold",
			widest, tallest);
		if (fail_count == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

endmodule
